// ===== src/bdq_pkg.sv =====
`default_nettype none

package bdq_pkg;

    localparam int CAPACITY_DEF = 32;
    localparam int KEY_W        = 32;
    localparam int KIND_W       = 3;
    localparam int STATUS_W     = 2;
    localparam int COUNT_W      = 6;

    localparam logic [KIND_W-1:0] KIND_INSERT    = 3'd0;
    localparam logic [KIND_W-1:0] KIND_DEL_KEY   = 3'd1;
    localparam logic [KIND_W-1:0] KIND_DEL_FIRST = 3'd2;
    localparam logic [KIND_W-1:0] KIND_DEL_LAST  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_DUMP      = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

    typedef struct packed {
        logic [KIND_W-1:0]       kind;
        logic signed [KEY_W-1:0] key;
    } item_t;

    typedef struct packed {
        logic [STATUS_W-1:0]     status;
        logic signed [KEY_W-1:0] value;
        logic [COUNT_W-1:0]      count;
        logic                    last;
    } result_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DISPATCH,
        S_SCAN,
        S_RESP
    } state_t;

    typedef struct packed {
        logic                capture;
        logic                ins;
        logic                pop_front;
        logic                pop_back;
        logic                scan_start;
        logic                scan_issue;
        logic                drop_one;
        logic                emit;
        logic                set_status;
        logic [STATUS_W-1:0] status;
    } ctl_cmd_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              empty;
        logic              full;
        logic              issue_done;
        logic              pending;
        logic              found;
    } ctl_sts_t;

endpackage

`default_nettype wire

// ===== src/bdq_ram.sv =====
`default_nettype none

module bdq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== src/bdq_ctrl.sv =====
`default_nettype none

module bdq_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire bdq_pkg::ctl_sts_t sts,
    output bdq_pkg::ctl_cmd_t     cmd,
    output logic                  busy
);

    bdq_pkg::state_t state_reg;
    bdq_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bdq_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            bdq_pkg::S_IDLE:
            begin
                if (start)
                begin
                    cmd.capture = 1'b1;
                    state_next  = bdq_pkg::S_DISPATCH;
                end
            end
            bdq_pkg::S_DISPATCH:
            begin
                state_next     = bdq_pkg::S_RESP;
                cmd.set_status = 1'b1;
                cmd.status     = bdq_pkg::ST_OK;
                case (sts.kind)
                    bdq_pkg::KIND_INSERT:
                    begin
                        if (sts.full)
                        begin
                            cmd.status = bdq_pkg::ST_FULL;
                        end
                        else
                        begin
                            cmd.ins = 1'b1;
                        end
                    end
                    bdq_pkg::KIND_DEL_FIRST:
                    begin
                        if (sts.empty)
                        begin
                            cmd.status = bdq_pkg::ST_EMPTY;
                        end
                        else
                        begin
                            cmd.pop_front = 1'b1;
                        end
                    end
                    bdq_pkg::KIND_DEL_LAST:
                    begin
                        if (sts.empty)
                        begin
                            cmd.status = bdq_pkg::ST_EMPTY;
                        end
                        else
                        begin
                            cmd.pop_back = 1'b1;
                        end
                    end
                    bdq_pkg::KIND_DEL_KEY, bdq_pkg::KIND_DUMP:
                    begin
                        if (sts.empty)
                        begin
                            cmd.status = bdq_pkg::ST_EMPTY;
                        end
                        else
                        begin
                            cmd.set_status = 1'b0;
                            cmd.scan_start = 1'b1;
                            state_next     = bdq_pkg::S_SCAN;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            bdq_pkg::S_SCAN:
            begin
                if (!sts.issue_done)
                begin
                    cmd.scan_issue = 1'b1;
                end
                else if (!sts.pending)
                begin
                    if (sts.kind == bdq_pkg::KIND_DUMP)
                    begin
                        state_next = bdq_pkg::S_IDLE;
                    end
                    else
                    begin
                        cmd.set_status = 1'b1;
                        cmd.status     = sts.found ? bdq_pkg::ST_OK : bdq_pkg::ST_NOT_FOUND;
                        cmd.drop_one   = sts.found;
                        state_next     = bdq_pkg::S_RESP;
                    end
                end
            end
            bdq_pkg::S_RESP:
            begin
                cmd.emit   = 1'b1;
                state_next = bdq_pkg::S_IDLE;
            end
            default:
            begin
                state_next = bdq_pkg::S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != bdq_pkg::S_IDLE);

endmodule

`default_nettype wire

// ===== src/bdq_datapath.sv =====
`default_nettype none

module bdq_datapath #(
    parameter int CAPACITY = bdq_pkg::CAPACITY_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire bdq_pkg::item_t    item,
    input  wire bdq_pkg::ctl_cmd_t cmd,
    output bdq_pkg::ctl_sts_t      sts,
    output bdq_pkg::result_t       result,
    output logic                   strobe
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int SW = CW + 1;

    localparam logic [CW-1:0] CAP_C  = CW'(CAPACITY);
    localparam logic [AW-1:0] LAST_A = AW'(CAPACITY - 1);

    logic [bdq_pkg::KIND_W-1:0]       kind_reg;
    logic signed [bdq_pkg::KEY_W-1:0] key_reg;
    logic [AW-1:0]                    head_reg;
    logic [AW-1:0]                    head_next;
    logic [CW-1:0]                    cnt_reg;
    logic [CW-1:0]                    cnt_next;
    logic [CW-1:0]                    rd_idx_reg;
    logic [CW-1:0]                    rd_idx_next;
    logic                             rv_reg;
    logic [CW-1:0]                    ri_reg;
    logic                             found_reg;
    logic                             found_next;
    logic [bdq_pkg::STATUS_W-1:0]     st_reg;
    bdq_pkg::result_t                 res_reg;
    bdq_pkg::result_t                 res_next;
    logic                             strobe_reg;
    logic                             strobe_next;

    logic [AW-1:0]                    head_dec;
    logic [AW-1:0]                    head_inc;
    logic                             del_mode;
    logic                             dump_mode;
    logic                             match_now;
    logic                             shift_we;
    logic                             ram_we;
    logic [AW-1:0]                    ram_waddr;
    logic [bdq_pkg::KEY_W-1:0]        ram_wdata;
    logic [AW-1:0]                    ram_raddr;
    logic [bdq_pkg::KEY_W-1:0]        ram_rdata;

    // logical position to ram address, ring starting at head
    function automatic logic [AW-1:0] phys(input logic [AW-1:0] base, input logic [CW-1:0] idx);
        logic [SW-1:0] s;
        s = SW'(base) + SW'(idx);
        if (s >= SW'(CAPACITY))
        begin
            s = s - SW'(CAPACITY);
        end
        return AW'(s);
    endfunction

    assign head_dec  = (head_reg == '0) ? LAST_A : head_reg - AW'(1);
    assign head_inc  = (head_reg == LAST_A) ? '0 : head_reg + AW'(1);
    assign del_mode  = (kind_reg == bdq_pkg::KIND_DEL_KEY);
    assign dump_mode = (kind_reg == bdq_pkg::KIND_DUMP);
    assign match_now = rv_reg && del_mode && !found_reg && ($signed(ram_rdata) == key_reg);
    assign shift_we  = rv_reg && del_mode && found_reg;

    assign ram_we    = cmd.ins || shift_we;
    assign ram_waddr = cmd.ins ? head_dec : phys(head_reg, ri_reg - CW'(1));
    assign ram_wdata = cmd.ins ? key_reg : ram_rdata;
    assign ram_raddr = phys(head_reg, rd_idx_reg);

    bdq_ram #(
        .WIDTH (bdq_pkg::KEY_W),
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        head_next = head_reg;
        cnt_next  = cnt_reg;
        if (cmd.ins)
        begin
            head_next = head_dec;
            cnt_next  = cnt_reg + CW'(1);
        end
        else if (cmd.pop_front)
        begin
            head_next = head_inc;
            cnt_next  = cnt_reg - CW'(1);
        end
        else if (cmd.pop_back || cmd.drop_one)
        begin
            cnt_next = cnt_reg - CW'(1);
        end
    end

    always_comb
    begin
        rd_idx_next = rd_idx_reg;
        found_next  = found_reg;
        if (cmd.scan_start)
        begin
            rd_idx_next = '0;
            found_next  = 1'b0;
        end
        else
        begin
            if (cmd.scan_issue)
            begin
                rd_idx_next = rd_idx_reg + CW'(1);
            end
            if (match_now)
            begin
                found_next = 1'b1;
            end
        end
    end

    always_comb
    begin
        res_next    = res_reg;
        strobe_next = 1'b0;
        if (cmd.emit)
        begin
            strobe_next    = 1'b1;
            res_next.status = st_reg;
            res_next.value  = '0;
            res_next.count  = bdq_pkg::COUNT_W'(cnt_reg);
            res_next.last   = 1'b1;
        end
        else if (rv_reg && dump_mode)
        begin
            strobe_next    = 1'b1;
            res_next.status = bdq_pkg::ST_OK;
            res_next.value  = $signed(ram_rdata);
            res_next.count  = bdq_pkg::COUNT_W'(cnt_reg);
            res_next.last   = (ri_reg + CW'(1) == cnt_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg   <= '0;
            cnt_reg    <= '0;
            rd_idx_reg <= '0;
            rv_reg     <= 1'b0;
            found_reg  <= 1'b0;
            st_reg     <= bdq_pkg::ST_OK;
            strobe_reg <= 1'b0;
        end
        else
        begin
            head_reg   <= head_next;
            cnt_reg    <= cnt_next;
            rd_idx_reg <= rd_idx_next;
            rv_reg     <= cmd.scan_issue;
            found_reg  <= found_next;
            if (cmd.set_status)
            begin
                st_reg <= cmd.status;
            end
            strobe_reg <= strobe_next;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            kind_reg <= item.kind;
            key_reg  <= item.key;
        end
        ri_reg  <= rd_idx_reg;
        res_reg <= res_next;
    end

    assign sts.kind       = kind_reg;
    assign sts.empty      = (cnt_reg == '0);
    assign sts.full       = (cnt_reg == CAP_C);
    assign sts.issue_done = (rd_idx_reg == cnt_reg);
    assign sts.pending    = rv_reg;
    assign sts.found      = found_reg;

    assign result = res_reg;
    assign strobe = strobe_reg;

`ifndef ASSERT_OFF
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CAP_C)
        else $error("occupancy above capacity");

    a_no_ins_full: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.ins |-> (cnt_reg != CAP_C))
        else $error("insert into full list");

    a_write_clash: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.ins && shift_we))
        else $error("insert and shift write in the same cycle");

    a_read_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        rv_reg |-> (ri_reg < cnt_reg))
        else $error("read beyond held entries");
`endif

endmodule

`default_nettype wire

// ===== src/bounded_deque_with_key_delete.sv =====
`default_nettype none

// ordered list of up to CAPACITY signed keys held in a ring buffer in one ram with a
// registered read port; a word is taken when start is high and busy is low, and each
// result word shows on result for exactly one cycle with strobe high, so the receiver
// must take it then and cannot stall it. insert, delete first, delete last, unused kinds
// and any delete or dump on an empty list keep busy high through the dispatch and response
// states and give one status word from the output register; delete by key and dump walk
// the list one entry per cycle through the ram read port, and a dump gives one word per
// held key, front to back, last set on the back one

module bounded_deque_with_key_delete #(
    parameter int CAPACITY = bdq_pkg::CAPACITY_DEF
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           start,
    output logic                busy,
    input  wire bdq_pkg::item_t item,
    output bdq_pkg::result_t    result,
    output logic                strobe
);

    bdq_pkg::ctl_cmd_t cmd;
    bdq_pkg::ctl_sts_t sts;

    bdq_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy)
    );

    bdq_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .cmd    (cmd),
        .sts    (sts),
        .result (result),
        .strobe (strobe)
    );

endmodule

`default_nettype wire
